FILE: rtl/assert_macros.svh
// assertion macros for the rtl
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define NPS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("nps assertion failed");

// condition must never be true outside reset
`define NPS_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("nps forbidden condition seen");

`endif

FILE: rtl/nps_pkg.sv
// package for the nearest palette colour search
// constants, command codes and controller/datapath interface structs; no dependencies
package nps_pkg;

  localparam int unsigned PaletteDepthDefault = 256;
  localparam int unsigned ColorW = 8;
  localparam int unsigned IndexW = 8;
  localparam int unsigned DistW  = 20;
  localparam int unsigned EntryW = 3 * ColorW + 1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic clear_we;
    logic host_we;
    logic load;
    logic rd_en;
  } nps_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } nps_status_t;

endpackage

FILE: rtl/nearest_palette_color_search.sv
// top level of the nearest palette colour search (redmean distance)
// depends on nps_pkg, nps_ctrl, nps_dp, nps_ram and assert_macros.svh
//
//   port group   direction  handshake            carries
//   request      in         start_i & !busy_o    command, entry index/valid, colour
//   result       out        done_o (one cycle)   found, best index, distance, exact
//
// after reset a clearing pass writes every palette slot invalid, busy_o high throughout
// a write request gives no result and leaves the block idle
// a query reads one slot per cycle from the palette ram read port, then drains the
// distance pipeline: done_o follows once the pipeline is empty, which comes sooner when
// the last slots are invalid
// results cannot be stalled; done_o is high for exactly one cycle per query, with busy_o
// already low so the next request can be taken at the edge that ends it
`include "assert_macros.svh"

module nearest_palette_color_search import nps_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = PaletteDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              command_i,
  input  logic [IndexW-1:0] entry_index_i,
  input  logic              entry_valid_i,
  input  logic [ColorW-1:0] red_i,
  input  logic [ColorW-1:0] green_i,
  input  logic [ColorW-1:0] blue_i,
  output logic              done_o,
  output logic              found_o,
  output logic [IndexW-1:0] best_index_o,
  output logic [DistW-1:0]  best_distance_o,
  output logic              exact_match_o
);

  localparam int unsigned AddrW = $clog2(PALETTE_DEPTH);

  // command and status between controller and datapath
  nps_cmd_t         cmd;
  nps_status_t      status;
  logic [AddrW-1:0] addr;

  nps_ctrl #(
    .PaletteDepth (PALETTE_DEPTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .status_i  (status),
    .cmd_o     (cmd),
    .addr_o    (addr),
    .busy_o    (busy_o),
    .done_o    (done_o)
  );

  nps_dp #(
    .PaletteDepth (PALETTE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .addr_i          (addr),
    .entry_index_i   (entry_index_i),
    .entry_valid_i   (entry_valid_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .status_o        (status),
    .found_o         (found_o),
    .best_index_o    (best_index_o),
    .best_distance_o (best_distance_o),
    .exact_match_o   (exact_match_o)
  );

  // a result is only shown while the block is idle
  `NPS_ASSERT_NEVER(a_done_idle, clk_i, rst_ni, done_o && busy_o)
  // an empty palette gives an all-zero result
  `NPS_ASSERT(a_empty_zero, clk_i, rst_ni, (done_o && !found_o) |-> (best_index_o == '0 && best_distance_o == '0 && !exact_match_o))
  // an exact hit has zero distance and counts as found
  `NPS_ASSERT(a_exact_zero, clk_i, rst_ni, (done_o && exact_match_o) |-> (found_o && best_distance_o == '0))
  // the result strobe drops straight after it is raised
  `NPS_ASSERT(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o)

endmodule

FILE: rtl/nps_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module nps_ram #(
  parameter int unsigned Width = 25,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/nps_ctrl.sv
// controller for the nearest palette colour search: clear pass, scan, drain, result strobe
// depends on nps_pkg
module nps_ctrl import nps_pkg::*; #(
  parameter int unsigned PaletteDepth = PaletteDepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            command_i,
  input  nps_status_t                     status_i,
  output nps_cmd_t                        cmd_o,
  output logic [$clog2(PaletteDepth)-1:0] addr_o,
  output logic                            busy_o,
  output logic                            done_o
);

  localparam int unsigned AddrW = $clog2(PaletteDepth);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(PaletteDepth - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  state_e           state_q;
  logic [AddrW-1:0] cnt_q;
  logic             done_q;
  logic             accept;

  assign accept = start_i && (state_q == ST_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.clear_we = (state_q == ST_CLEAR);
    cmd_o.rd_en    = (state_q == ST_SCAN);
    cmd_o.host_we  = accept && (command_i == CMD_WRITE);
    cmd_o.load     = accept && (command_i == CMD_QUERY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == ST_DRAIN) && !status_i.pipe_busy;
      unique case (state_q)
        ST_CLEAR: begin
          if (cnt_q == LastAddr) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept && (command_i == CMD_QUERY)) begin
            cnt_q   <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt_q == LastAddr) begin
            cnt_q   <= '0;
            state_q <= ST_DRAIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!status_i.pipe_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign addr_o = cnt_q;
  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

FILE: rtl/nps_dp.sv
// datapath for the nearest palette colour search: palette ram, distance pipeline, best tracker
// depends on nps_pkg and nps_ram
module nps_dp import nps_pkg::*; #(
  parameter int unsigned PaletteDepth = PaletteDepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  nps_cmd_t                        cmd_i,
  input  logic [$clog2(PaletteDepth)-1:0] addr_i,
  input  logic [IndexW-1:0]               entry_index_i,
  input  logic                            entry_valid_i,
  input  logic [ColorW-1:0]               red_i,
  input  logic [ColorW-1:0]               green_i,
  input  logic [ColorW-1:0]               blue_i,
  output nps_status_t                     status_o,
  output logic                            found_o,
  output logic [IndexW-1:0]               best_index_o,
  output logic [DistW-1:0]                best_distance_o,
  output logic                            exact_match_o
);

  localparam int unsigned AddrW = $clog2(PaletteDepth);
  // wide enough for the host index, a slot number and the depth itself
  localparam int unsigned ExtW  = ((AddrW > IndexW) ? AddrW : IndexW) + 1;

  // host write and clear pass share the ram write port
  logic [ExtW-1:0]   entry_ext;
  logic              in_range;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic [EntryW-1:0] ram_rdata;

  assign entry_ext = ExtW'(entry_index_i);
  assign in_range  = entry_ext < ExtW'(PaletteDepth);
  assign ram_we    = cmd_i.clear_we || (cmd_i.host_we && in_range);
  assign ram_waddr = cmd_i.clear_we ? addr_i : entry_ext[AddrW-1:0];
  assign ram_wdata = cmd_i.clear_we ? '0 : {entry_valid_i, red_i, green_i, blue_i};

  nps_ram #(
    .Width (EntryW),
    .Depth (PaletteDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (addr_i),
    .rdata_o (ram_rdata)
  );

  // query colour
  logic [ColorW-1:0] qr_q, qg_q, qb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      qr_q <= red_i;
      qg_q <= green_i;
      qb_q <= blue_i;
    end
  end

  // pipeline valid bits
  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  logic [AddrW-1:0] idx0_q, idx1_q, idx2_q, idx3_q, idx4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.rd_en;
      v1_q <= v0_q && ram_rdata[EntryW-1];
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: differences, mean red, exact compare
  logic [ColorW-1:0]       er, eg, eb;
  logic signed [ColorW:0]  dr1_q, dg1_q, db1_q;
  logic [ColorW-1:0]       rm1_q;
  logic                    ex1_q;
  logic [ColorW:0]         rsum;

  assign er   = ram_rdata[3*ColorW-1:2*ColorW];
  assign eg   = ram_rdata[2*ColorW-1:ColorW];
  assign eb   = ram_rdata[ColorW-1:0];
  assign rsum = {1'b0, er} + {1'b0, qr_q};

  always_ff @(posedge clk_i) begin
    idx0_q <= addr_i;
    idx1_q <= idx0_q;
    dr1_q  <= $signed({1'b0, er}) - $signed({1'b0, qr_q});
    dg1_q  <= $signed({1'b0, eg}) - $signed({1'b0, qg_q});
    db1_q  <= $signed({1'b0, eb}) - $signed({1'b0, qb_q});
    rm1_q  <= rsum[ColorW:1];
    ex1_q  <= (er == qr_q) && (eg == qg_q) && (eb == qb_q);
  end

  // stage 2: squares
  logic signed [2*ColorW+1:0] sqr, sqg, sqb;
  logic [2*ColorW-1:0]        dr2_q, dg2_q, db2_q;
  logic [ColorW-1:0]          rm2_q;
  logic                       ex2_q;

  assign sqr = dr1_q * dr1_q;
  assign sqg = dg1_q * dg1_q;
  assign sqb = db1_q * db1_q;

  always_ff @(posedge clk_i) begin
    idx2_q <= idx1_q;
    dr2_q  <= sqr[2*ColorW-1:0];
    dg2_q  <= sqg[2*ColorW-1:0];
    db2_q  <= sqb[2*ColorW-1:0];
    rm2_q  <= rm1_q;
    ex2_q  <= ex1_q;
  end

  // stage 3: weighted sum and red correction product
  localparam int unsigned ProdW = 3 * ColorW + 2;
  logic signed [2*ColorW:0]  sqdiff;
  logic signed [ProdW-1:0]   prod;
  logic [DistW-1:0]          base3_q;
  logic signed [ProdW-1:0]   prod3_q;
  logic                      ex3_q;

  assign sqdiff = $signed({1'b0, dr2_q}) - $signed({1'b0, db2_q});
  assign prod   = $signed({1'b0, rm2_q}) * sqdiff;

  always_ff @(posedge clk_i) begin
    idx3_q  <= idx2_q;
    base3_q <= (DistW'(dr2_q) << 1) + (DistW'(dg2_q) << 2)
             + (DistW'(db2_q) << 1) + DistW'(db2_q);
    prod3_q <= prod;
    ex3_q   <= ex2_q;
  end

  // stage 4: divide by 256 toward zero and add
  logic signed [ProdW-1:0]   prod_adj;
  logic signed [ProdW-1:0]   term;
  logic signed [DistW:0]     dsum;
  logic [DistW-1:0]          dist4_q;
  logic                      ex4_q;

  assign prod_adj = prod3_q + (prod3_q[ProdW-1] ? ProdW'(255) : ProdW'(0));
  assign term     = prod_adj >>> 8;
  assign dsum     = $signed({1'b0, base3_q}) + $signed(term[DistW:0]);

  always_ff @(posedge clk_i) begin
    idx4_q  <= idx3_q;
    dist4_q <= dsum[DistW-1:0];
    ex4_q   <= ex3_q;
  end

  // stage 5: best tracker, frozen after an exact hit
  logic             found_q, exact_q, stop_q;
  logic [AddrW-1:0] best_idx_q;
  logic [DistW-1:0] best_dist_q;
  logic [ExtW-1:0]  best_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      exact_q     <= 1'b0;
      stop_q      <= 1'b0;
      best_idx_q  <= '0;
      best_dist_q <= '0;
    end else if (cmd_i.load) begin
      found_q     <= 1'b0;
      exact_q     <= 1'b0;
      stop_q      <= 1'b0;
      best_idx_q  <= '0;
      best_dist_q <= '0;
    end else if (v4_q && !stop_q) begin
      priority if (ex4_q) begin
        found_q     <= 1'b1;
        exact_q     <= 1'b1;
        stop_q      <= 1'b1;
        best_idx_q  <= idx4_q;
        best_dist_q <= '0;
      end else if (!found_q || (dist4_q < best_dist_q)) begin
        found_q     <= 1'b1;
        best_idx_q  <= idx4_q;
        best_dist_q <= dist4_q;
      end else begin
        // farther or tied: the earlier slot stays
      end
    end
  end

  assign best_ext           = ExtW'(best_idx_q);
  assign status_o.pipe_busy = v0_q || v1_q || v2_q || v3_q || v4_q;
  assign found_o            = found_q;
  assign exact_match_o      = exact_q;
  assign best_index_o       = best_ext[IndexW-1:0];
  assign best_distance_o    = best_dist_q;

endmodule
